/* design/larb_pkg.sv */
// Package: constants, action codes and front-to-back command type.
`default_nettype none
package larb_pkg;
  localparam int unsigned Depth = 256;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChGt = 8'h3E;
  localparam logic [7:0] ChSp = 8'h20;

  typedef enum logic [2:0] {
    ActRx = 3'd0, ActCount = 3'd1, ActLocate = 3'd2,
    ActRead = 3'd3, ActRemove = 3'd4, ActClear = 3'd5,
    ActBad6 = 3'd6, ActBad7 = 3'd7
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] rx_byte;
    logic [7:0] num;
    logic [7:0] pos;
  } cmd_t;
endpackage
`default_nettype wire

/* design/line_answer_receive_buffer_unit.sv */
// Line answer receive buffer: answers delimited by CR in a 256-byte store.
// Receive and read pass through the load and done states to the result; a
// receive that inserts a CR also passes the CR state. Count, locate and remove
// walk the store up to the fill, one byte per cycle.
// Throughput: one item at a time in the back; a two-beat queue decouples input.
// Reset empties the buffer; store contents are undefined until written.
`default_nettype none
module line_answer_receive_buffer_unit import larb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] answer_number_i,
  input  wire logic [7:0] byte_position_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            status_o,
  output logic [8:0]      answer_total_o,
  output logic [8:0]      answer_start_o,
  output logic [8:0]      answer_length_o,
  output logic [7:0]      read_value_o,
  output logic [8:0]      fill_level_o
);
  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_take;

  assign in_cmd = '{action: action_e'(action_i), rx_byte: rx_byte_i,
                    num: answer_number_i, pos: byte_position_i};

  larb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_cmd_i(in_cmd),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  larb_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .status_o, .answer_total_o, .answer_start_o,
    .answer_length_o, .read_value_o, .fill_level_o
  );
endmodule
`default_nettype wire

/* design/larb_front.sv */
// Front: two-entry command queue.
`default_nettype none
module larb_front import larb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire cmd_t       in_cmd_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_take_i,
  output cmd_t            cmd_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = mem_q[rp_q];

  // Store incoming beats
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* design/larb_back.sv */
// Back: sequencer over the character store that carries out each command.
`default_nettype none
module larb_back import larb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_take_o,
  input  wire cmd_t       cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            status_o,
  output logic [8:0]      answer_total_o,
  output logic [8:0]      answer_start_o,
  output logic [8:0]      answer_length_o,
  output logic [7:0]      read_value_o,
  output logic [8:0]      fill_level_o
);
  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StLoad = 7'b0000010, StCr = 7'b0000100,
    StScan = 7'b0001000, StShift = 7'b0010000, StDone = 7'b0100000,
    StOut = 7'b1000000
  } state_e;

  state_e        st_q;
  cmd_t          c_q;
  logic [CW-1:0] fill_q, i_q, pidx_q, s_q, len_q;
  logic          pend_q;    // rd_q holds the byte at pidx_q
  logic [7:0]    n_q;       // separators still to pass
  logic [8:0]    tot_q;
  logic          found_q;   // start of wanted answer reached
  logic [7:0]    mem [Depth];
  logic [7:0]    rd_q;
  logic          st_o_q;
  logic [8:0]    o_tot_q, o_st_q, o_len_q, o_fill_q;
  logic [7:0]    o_rv_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;
  logic          is_cr, ins_cr, drop_rx, scan_more, term;

  assign cmd_take_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign status_o = st_o_q;
  assign answer_total_o = o_tot_q;
  assign answer_start_o = o_st_q;
  assign answer_length_o = o_len_q;
  assign read_value_o = o_rv_q;
  assign fill_level_o = o_fill_q;

  // Classify the received byte against the byte below it
  assign is_cr     = (rd_q == ChCr);
  assign ins_cr    = (fill_q != '0) && (rd_q == ChGt) && (c_q.rx_byte == ChSp)
                     && (fill_q + CW'(1) < CW'(Depth));
  assign drop_rx   = (c_q.rx_byte == ChLf) ||
                     ((c_q.rx_byte == ChCr) && ((fill_q == '0) || (rd_q == ChCr)));
  assign scan_more = (i_q < fill_q);
  assign term      = pend_q && is_cr && found_q;

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // Read address: byte below the fill, read position, or walk index
  always_comb begin
    ra = i_q[AW-1:0];
    if (st_q == StIdle) begin
      if (cmd_i.action == ActRx) ra = AW'(fill_q - CW'(1));
      else if (cmd_i.action == ActRead) ra = AW'(cmd_i.pos);
    end
  end

  // Write port: receive, inserted CR, shift-down
  always_comb begin
    we = 1'b0; wa = fill_q[AW-1:0]; wd = c_q.rx_byte;
    if (st_q == StLoad && c_q.action == ActRx && fill_q < CW'(Depth)) begin
      we = 1'b1;
    end else if (st_q == StCr) begin
      we = 1'b1; wd = ChCr;
    end else if (st_q == StShift && pend_q) begin
      we = 1'b1; wa = AW'(pidx_q - len_q); wd = rd_q;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fill_q <= '0; c_q <= '0;
      i_q <= '0; pidx_q <= '0; s_q <= '0; len_q <= '0; pend_q <= 1'b0;
      n_q <= '0; tot_q <= '0; found_q <= 1'b0; st_o_q <= 1'b0;
      o_tot_q <= '0; o_st_q <= '0; o_len_q <= '0; o_rv_q <= '0; o_fill_q <= '0;
    end else begin
      case (st_q)
        StIdle: if (cmd_valid_i) begin
          c_q <= cmd_i; i_q <= '0; pend_q <= 1'b0; tot_q <= '0;
          found_q <= (cmd_i.num == 8'd0);
          n_q <= cmd_i.num; s_q <= '0; st_o_q <= 1'b0;
          o_tot_q <= '0; o_st_q <= '0; o_len_q <= '0; o_rv_q <= '0;
          case (cmd_i.action)
            ActRx, ActRead: st_q <= StLoad;
            ActCount, ActLocate, ActRemove: st_q <= StScan;
            ActClear: begin fill_q <= '0; st_q <= StDone; end
            default: begin st_o_q <= 1'b1; st_q <= StDone; end
          endcase
        end
        StLoad: begin
          if (c_q.action == ActRead) begin
            if (CW'(c_q.pos) < fill_q) o_rv_q <= rd_q; else st_o_q <= 1'b1;
            st_q <= StDone;
          end else if (fill_q >= CW'(Depth)) begin
            st_q <= StDone;
          end else if (ins_cr) begin
            fill_q <= fill_q + CW'(1); st_q <= StCr;
          end else begin
            if (!drop_rx) fill_q <= fill_q + CW'(1);
            st_q <= StDone;
          end
        end
        StCr: begin
          // CR after stored space: keep it
          fill_q <= fill_q + CW'(1); st_q <= StDone;
        end
        StScan: begin
          // one byte per cycle; rd_q holds the byte at pidx_q when pend_q is set
          if (term && c_q.action == ActLocate) begin
            o_st_q <= s_q; o_len_q <= pidx_q - s_q; st_q <= StDone;
          end else if (term && c_q.action == ActRemove) begin
            len_q <= pidx_q - s_q + CW'(1);
            i_q <= pidx_q + CW'(1); pend_q <= 1'b0; st_q <= StShift;
          end else if (!pend_q && !scan_more) begin
            // end of fill
            st_q <= StDone;
            case (c_q.action)
              ActCount: o_tot_q <= tot_q;
              ActLocate: if (found_q) begin
                o_st_q <= s_q; o_len_q <= fill_q - s_q;
              end else st_o_q <= 1'b1;
              default: st_o_q <= 1'b1;
            endcase
          end else begin
            pend_q <= scan_more; pidx_q <= i_q;
            if (scan_more) i_q <= i_q + CW'(1);
            if (pend_q && is_cr) begin
              tot_q <= tot_q + 9'd1;
              if (!found_q) begin
                if (n_q == 8'd1) begin found_q <= 1'b1; s_q <= pidx_q + CW'(1); end
                n_q <= n_q - 8'd1;
              end
            end
          end
        end
        StShift: begin
          // move the bytes above the removed answer down by its length
          if (!pend_q && !scan_more) begin
            fill_q <= fill_q - len_q; st_q <= StDone;
          end else begin
            pend_q <= scan_more; pidx_q <= i_q;
            if (scan_more) i_q <= i_q + CW'(1);
          end
        end
        StDone: begin o_fill_q <= fill_q; st_q <= StOut; end
        StOut: if (!out_stall_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/larb_checker.sv */
// Port-level checker for the receive buffer, bound to the top level.
`default_nettype none
module larb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       status_o,
  input wire logic [8:0] answer_total_o,
  input wire logic [7:0] read_value_o,
  input wire logic [8:0] fill_level_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= 9'd256) else $error("fill too large");
  a_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> answer_total_o <= fill_level_o) else $error("count beyond fill");
  a_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> read_value_o == 8'd0) else $error("value on error");
endmodule

bind line_answer_receive_buffer_unit larb_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .status_o, .answer_total_o,
  .read_value_o, .fill_level_o
);
`default_nettype wire
